// ===== rtl/core/qppl_pkg.sv =====
// ----------------------------------------------------------------------------
// qppl_pkg: shared definitions for the quadrature PI position loop
// Field widths, event and register codes, reset values and the queue status.
// ----------------------------------------------------------------------------
package qppl_pkg;

    // Event codes
    localparam logic [1:0] MODE_A_EDGE = 2'd0;
    localparam logic [1:0] MODE_B_EDGE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROP_GAIN     = 2'd0;
    localparam logic [1:0] CFG_INTEGRAL_GAIN = 2'd1;

    // Field widths
    localparam int MODE_W      = 2;
    localparam int REF_W       = 11;
    localparam int MAG_W       = 8;
    localparam int POS_OUT_W   = 24;
    localparam int PROP_GAIN_W = 16;
    localparam int INT_GAIN_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Reset values of the gains: 10.0 in Q8.8, about 0.0001 in Q0.24
    localparam logic [PROP_GAIN_W-1:0] PROP_GAIN_RESET = 16'd2560;
    localparam logic [INT_GAIN_W-1:0]  INT_GAIN_RESET  = 24'd1678;

    // The drive sum is kept in units of 2^-26; P term carries 2^-10
    localparam int DRIVE_FRAC_W = 26;
    localparam int PTERM_SHIFT  = 16;

    // Defaults of the top-level parameters
    localparam int DEFAULT_POSITION_BITS = 24;
    localparam int DEFAULT_SUM_BITS      = 40;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/qppl_if.sv =====
// ----------------------------------------------------------------------------
// qppl_if: channel interfaces of the quadrature PI position loop
// Event input, drive output and configuration write channels.
// ----------------------------------------------------------------------------
interface qppl_in_if;
    logic                           valid;
    logic                           ready;
    logic [qppl_pkg::MODE_W-1:0]    mode;
    logic                           level_a;
    logic                           level_b;
    logic signed [qppl_pkg::REF_W-1:0] reference;

    modport source (output valid, output mode, output level_a, output level_b,
                    output reference, input ready);
    modport sink   (input valid, input mode, input level_a, input level_b,
                    input reference, output ready);
endinterface

interface qppl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [qppl_pkg::MAG_W-1:0]            drive_magnitude;
    logic                                  direction;
    logic signed [qppl_pkg::POS_OUT_W-1:0] position_now;

    modport source (output valid, output drive_magnitude, output direction,
                    output position_now, input ready);
    modport sink   (input valid, input drive_magnitude, input direction,
                    input position_now, output ready);
endinterface

interface qppl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qppl_pkg::CFG_IDX_W-1:0]    index;
    logic [qppl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/qppl_queue.sv =====
// ----------------------------------------------------------------------------
// qppl_queue: short FIFO between the event front end and the loop back end
// Register array with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module qppl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qppl_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_push_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_pop_data,
    output qppl_pkg::t_q_status o_status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_entries [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_entries[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
endmodule

// ===== rtl/core/qppl_front.sv =====
// ----------------------------------------------------------------------------
// qppl_front: event front end
// Decode encoder edges into the position counter; queue ticks with their error.
// ----------------------------------------------------------------------------
module qppl_front #(
    parameter int POSITION_BITS = qppl_pkg::DEFAULT_POSITION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    qppl_in_if.sink                  i_in,
    input  qppl_pkg::t_q_status      i_q_status,
    output logic                     o_push,
    output logic [2*POSITION_BITS:0] o_push_data
);
    localparam int ERR_W = POSITION_BITS + 1;

    logic [POSITION_BITS-1:0] r_position, n_position;
    logic                     accept;
    logic signed [ERR_W-1:0]  ref_ext;
    logic signed [ERR_W-1:0]  pos_ext;
    logic signed [ERR_W-1:0]  err;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    assign ref_ext = {{(ERR_W - qppl_pkg::REF_W){i_in.reference[qppl_pkg::REF_W-1]}},
                      i_in.reference};
    assign pos_ext = {r_position[POSITION_BITS-1], r_position};
    assign err     = ref_ext - pos_ext;

    always_comb begin
        n_position = r_position;
        o_push     = 1'b0;
        if (accept) begin
            unique case (i_in.mode)
                qppl_pkg::MODE_A_EDGE: begin
                    n_position = (i_in.level_a == i_in.level_b)
                               ? r_position + POSITION_BITS'(1)
                               : r_position - POSITION_BITS'(1);
                end
                qppl_pkg::MODE_B_EDGE: begin
                    n_position = (i_in.level_a != i_in.level_b)
                               ? r_position + POSITION_BITS'(1)
                               : r_position - POSITION_BITS'(1);
                end
                qppl_pkg::MODE_TICK: begin
                    o_push = 1'b1;
                end
                default: begin
                    // unused code: drop the event
                end
            endcase
        end
    end

    // snapshot of error and position as seen by this tick
    assign o_push_data = {err, r_position};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
        end else begin
            r_position <= n_position;
        end
    end
endmodule

// ===== rtl/core/qppl_back.sv =====
// ----------------------------------------------------------------------------
// qppl_back: PI loop back end
// Integrate the error, form the P and I terms and saturate the drive.
// ----------------------------------------------------------------------------
module qppl_back #(
    parameter int POSITION_BITS = qppl_pkg::DEFAULT_POSITION_BITS,
    parameter int SUM_BITS      = qppl_pkg::DEFAULT_SUM_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    qppl_cfg_if.sink                 i_cfg,
    input  logic [2*POSITION_BITS:0] i_q_data,
    input  qppl_pkg::t_q_status      i_q_status,
    output logic                     o_pop,
    qppl_out_if.source               o_out
);
    localparam int P          = POSITION_BITS;
    localparam int S          = SUM_BITS;
    localparam int ERR_W      = P + 1;
    localparam int ADD_W      = ((S > ERR_W) ? S : ERR_W) + 1;
    localparam int LO_W       = S / 2;
    localparam int HI_W       = S - LO_W;
    localparam int GI_W       = qppl_pkg::INT_GAIN_W;
    localparam int GP_W       = qppl_pkg::PROP_GAIN_W;
    localparam int LO_PROD_W  = LO_W + GI_W;
    localparam int HI_PROD_W  = HI_W + GI_W + 1;
    localparam int PTERM_W    = ERR_W + GP_W + 1;
    localparam int I_W        = S + GI_W + 1;
    localparam int PSH_W      = PTERM_W + qppl_pkg::PTERM_SHIFT;
    localparam int X_W        = ((I_W > PSH_W) ? I_W : PSH_W) + 1;
    localparam int FRAC_W     = qppl_pkg::DRIVE_FRAC_W;
    localparam int MAG_W      = qppl_pkg::MAG_W;
    localparam int EXT_W      = 64;

    // gains
    logic [GP_W-1:0] r_prop_gain;
    logic [GI_W-1:0] r_int_gain;

    // accumulator
    logic signed [S-1:0]     r_error_sum;
    logic signed [ADD_W-1:0] sum_wide;
    logic signed [S-1:0]     sum_new;
    logic                    sum_ovf;

    // pipeline
    logic                    en;
    logic                    r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic signed [ERR_W-1:0] q_err;
    logic [P-1:0]            q_pos;

    logic signed [ERR_W-1:0] r_s1_err;
    logic signed [S-1:0]     r_s1_sum;
    logic [P-1:0]            r_s1_pos;

    logic [LO_PROD_W-1:0]        r_s2_plo;
    logic signed [HI_PROD_W-1:0] r_s2_phi;
    logic signed [PTERM_W-1:0]   r_s2_pterm;
    logic [P-1:0]                r_s2_pos;

    logic signed [I_W-1:0]     r_s3_iterm;
    logic signed [PTERM_W-1:0] r_s3_pterm;
    logic [P-1:0]              r_s3_pos;

    logic signed [X_W-1:0] r_s4_x;
    logic [P-1:0]          r_s4_pos;

    logic signed [HI_PROD_W-1:0] phi_c;
    logic signed [PTERM_W-1:0]   pterm_c;
    logic signed [I_W-1:0]       iterm_c;
    logic signed [X_W-1:0]       x_c;
    logic [X_W-1:0]              abs_x;
    logic [MAG_W-1:0]            mag_c;
    logic [EXT_W-1:0]            pos_ext;

    logic [MAG_W-1:0]                  r_mag;
    logic                              r_dir;
    logic [qppl_pkg::POS_OUT_W-1:0]    r_pos_now;

    // configuration: always ready; to be written only while idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain <= qppl_pkg::PROP_GAIN_RESET;
            r_int_gain  <= qppl_pkg::INT_GAIN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                qppl_pkg::CFG_PROP_GAIN:     r_prop_gain <= i_cfg.data[GP_W-1:0];
                qppl_pkg::CFG_INTEGRAL_GAIN: r_int_gain  <= i_cfg.data[GI_W-1:0];
                default: begin
                    // no register: drop the write
                end
            endcase
        end
    end

    // whole pipeline advances when the output register can move
    assign en    = !r_out_valid || o_out.ready;
    assign o_pop = en && !i_q_status.empty;

    assign q_err = $signed(i_q_data[2*P:P]);
    assign q_pos = i_q_data[P-1:0];

    // saturating accumulate
    assign sum_wide = {{(ADD_W - S){r_error_sum[S-1]}}, r_error_sum}
                    + {{(ADD_W - ERR_W){q_err[ERR_W-1]}}, q_err};
    assign sum_ovf  = !((&sum_wide[ADD_W-1:S-1]) || !(|sum_wide[ADD_W-1:S-1]));
    assign sum_new  = sum_ovf ? (sum_wide[ADD_W-1] ? {1'b1, {(S-1){1'b0}}}
                                                   : {1'b0, {(S-1){1'b1}}})
                              : sum_wide[S-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
        end else if (o_pop) begin
            r_error_sum <= sum_new;
        end
    end

    // products: sum split into signed high and unsigned low halves
    assign phi_c   = $signed(r_s1_sum[S-1:LO_W]) * $signed({1'b0, r_int_gain});
    assign pterm_c = r_s1_err * $signed({1'b0, r_prop_gain});

    assign iterm_c = ({{(I_W - HI_PROD_W){r_s2_phi[HI_PROD_W-1]}}, r_s2_phi} <<< LO_W)
                   + I_W'(r_s2_plo);

    assign x_c = {{(X_W - I_W){r_s3_iterm[I_W-1]}}, r_s3_iterm}
               + ({{(X_W - PTERM_W){r_s3_pterm[PTERM_W-1]}}, r_s3_pterm}
                  <<< qppl_pkg::PTERM_SHIFT);

    // magnitude: floor(|x| / 2^26), held at full scale
    assign abs_x   = r_s4_x[X_W-1] ? X_W'(-r_s4_x) : r_s4_x;
    assign mag_c   = (|abs_x[X_W-1:FRAC_W+MAG_W]) ? {MAG_W{1'b1}}
                                                  : abs_x[FRAC_W+MAG_W-1:FRAC_W];
    assign pos_ext = {{(EXT_W - P){r_s4_pos[P-1]}}, r_s4_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_err   <= q_err;
            r_s1_sum   <= sum_new;
            r_s1_pos   <= q_pos;

            r_s2_plo   <= LO_PROD_W'(r_s1_sum[LO_W-1:0]) * LO_PROD_W'(r_int_gain);
            r_s2_phi   <= phi_c;
            r_s2_pterm <= pterm_c;
            r_s2_pos   <= r_s1_pos;

            r_s3_iterm <= iterm_c;
            r_s3_pterm <= r_s2_pterm;
            r_s3_pos   <= r_s2_pos;

            r_s4_x     <= x_c;
            r_s4_pos   <= r_s3_pos;

            r_mag      <= mag_c;
            r_dir      <= !r_s4_x[X_W-1] && (r_s4_x != '0);
            r_pos_now  <= pos_ext[qppl_pkg::POS_OUT_W-1:0];
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.drive_magnitude = r_mag;
    assign o_out.direction       = r_dir;
    assign o_out.position_now    = r_pos_now;
endmodule

// ===== rtl/core/quadrature_pi_position_loop_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_pi_position_loop_top: quadrature decoder with a PI position loop
// Counts encoder edges and produces a saturated drive on each control tick.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  -------  ---  -------------------  -----------------------------------------
//  i_in     in   valid/ready          mode, level_a, level_b, reference
//  o_out    out  valid/ready          drive_magnitude, direction, position_now
//  i_cfg    in   valid/ready (ready=1) index, data (prop_gain, integral_gain_dt)
//
//  One event is accepted per cycle while the queue is not full. Edges update the
//  position counter in the cycle they are accepted; a tick passes through the
//  queue, then the accumulate, multiply, sum, combine and saturate stages.
//  Synchronous active-low reset clears the position, the accumulator and all
//  valid state, and restores the gains to their defaults. An output stall
//  holds the back-end pipeline; ticks then collect in the four-entry queue,
//  and i_in.ready drops only when that queue is full.
//
module quadrature_pi_position_loop_top #(
    parameter int POSITION_BITS = qppl_pkg::DEFAULT_POSITION_BITS,
    parameter int SUM_BITS      = qppl_pkg::DEFAULT_SUM_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qppl_in_if.sink     i_in,
    qppl_cfg_if.sink    i_cfg,
    qppl_out_if.source  o_out
);
    localparam int Q_W = 2 * POSITION_BITS + 1;

    logic                q_push;
    logic [Q_W-1:0]      q_push_data;
    logic                q_pop;
    logic [Q_W-1:0]      q_pop_data;
    qppl_pkg::t_q_status q_status;

    // front: decode edges, snapshot error and position for ticks
    qppl_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // queue: lets the front keep counting edges while the output stalls
    qppl_queue #(
        .WIDTH (Q_W),
        .DEPTH (qppl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_status    (q_status)
    );

    // back: integrate, multiply, saturate, hold the result
    qppl_back #(
        .POSITION_BITS (POSITION_BITS),
        .SUM_BITS      (SUM_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_q_data   (q_pop_data),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

    // every accepted tick enters the queue, and nothing else does
    a_tick_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push == (i_in.valid && i_in.ready && i_in.mode == qppl_pkg::MODE_TICK))
        else $error("queue push does not match accepted tick");

    // never write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    // never read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a stalled output keeps the queue from draining
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !q_pop)
        else $error("queue drained while output stalled");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: quadrature PI position loop
// Drives encoder edges and control ticks through the event channel, and
// programs the gains between phases. A scoreboard tracks the position counter
// and the saturating accumulator. It predicts the drive of every tick and
// checks each drive transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import qppl_pkg::*;

    localparam int POSITION_BITS = DEFAULT_POSITION_BITS;
    localparam int SUM_BITS      = DEFAULT_SUM_BITS;
    // Extra wait after the last pending drive, to let the back end settle
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 130;
    localparam int REF_LIMIT     = 720;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    typedef struct packed {
        logic [MAG_W-1:0]            drive_magnitude;
        logic                        direction;
        logic signed [POS_OUT_W-1:0] position_now;
    } t_drive_result;

    // Tracks encoder position, accumulator and gains; holds pending drives.
    class drive_scoreboard;
        logic [PROP_GAIN_W-1:0]     prop_gain;
        logic [INT_GAIN_W-1:0]      int_gain;
        logic [POSITION_BITS-1:0]   position;
        logic signed [SUM_BITS-1:0] error_sum;
        t_drive_result              pending_drives[$];
        int unsigned                failures;

        function new();
            prop_gain = PROP_GAIN_RESET;
            int_gain  = INT_GAIN_RESET;
            position  = '0;
            error_sum = '0;
            failures  = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_PROP_GAIN)
                prop_gain = data[PROP_GAIN_W-1:0];
            else if (index == CFG_INTEGRAL_GAIN)
                int_gain = data[INT_GAIN_W-1:0];
        endfunction

        function int unsigned pending();
            return pending_drives.size();
        endfunction

        function void note_event(logic [MODE_W-1:0] mode, logic a, logic b,
                                 logic signed [REF_W-1:0] target);
            logic signed [31:0]       err;
            logic signed [SUM_BITS:0] sum_next;
            logic signed [79:0]       drive_u;
            logic [79:0]              drive_abs;
            logic [79:0]              whole;
            t_drive_result            res;
            case (mode)
                MODE_A_EDGE: position = (a == b) ? position + 1'b1 : position - 1'b1;
                MODE_B_EDGE: position = (a != b) ? position + 1'b1 : position - 1'b1;
                MODE_TICK: begin
                    err = target - $signed(position);
                    sum_next = error_sum + err;
                    // Clamp to the signed accumulator range on overflow
                    if (sum_next[SUM_BITS] != sum_next[SUM_BITS-1])
                        error_sum = sum_next[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                                       : {1'b0, {(SUM_BITS-1){1'b1}}};
                    else
                        error_sum = sum_next[SUM_BITS-1:0];
                    // Drive in units of 2^-26: P term carries 2^-10, I term 2^-26
                    drive_u = (($signed({1'b0, prop_gain}) * err) <<< PTERM_SHIFT)
                            + $signed({1'b0, int_gain}) * error_sum;
                    drive_abs = (drive_u < 0) ? -drive_u : drive_u;
                    whole = drive_abs >> DRIVE_FRAC_W;
                    res.drive_magnitude = (whole > MAG_MAX) ? MAG_MAX : whole[MAG_W-1:0];
                    res.direction       = (drive_u > 0);
                    res.position_now    = POS_OUT_W'($signed(position));
                    pending_drives.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_drive(logic [MAG_W-1:0] mag, logic dir,
                                  logic signed [POS_OUT_W-1:0] pos);
            t_drive_result want;
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected drive: magnitude %0d direction %0d position %0d",
                         $time, mag, dir, pos);
                failures++;
                return;
            end
            want = pending_drives.pop_front();
            if (mag !== want.drive_magnitude) begin
                $display("%0t: drive_magnitude expected %0d actual %0d",
                         $time, want.drive_magnitude, mag);
                failures++;
            end
            if (dir !== want.direction) begin
                $display("%0t: direction expected %0d actual %0d",
                         $time, want.direction, dir);
                failures++;
            end
            if (pos !== want.position_now) begin
                $display("%0t: position_now expected %0d actual %0d",
                         $time, want.position_now, pos);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    qppl_in_if  in_ch ();
    qppl_cfg_if cfg_ch ();
    qppl_out_if out_ch ();

    drive_scoreboard drive_sb = new();

    // Odds of a burst of idle cycles, per transaction for the source; zero means no idling
    int unsigned source_idle_odds = 0;
    int unsigned sink_stall_odds  = 0;

    // Current encoder levels for well-formed quadrature sequences
    logic enc_a = 1'b0;
    logic enc_b = 1'b0;

    quadrature_pi_position_loop_top #(
        .POSITION_BITS (POSITION_BITS),
        .SUM_BITS      (SUM_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Check every drive transaction that the sink accepts
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            drive_sb.check_drive(out_ch.drive_magnitude, out_ch.direction,
                                 out_ch.position_now);
    end

    // Sink side: hold ready high, drop it in random bursts when enabled
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Send one event, note it once accepted, then maybe leave a gap
    task automatic issue(input logic [MODE_W-1:0] mode, input logic a, input logic b,
                         input logic signed [REF_W-1:0] target);
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.level_a   <= a;
        in_ch.level_b   <= b;
        in_ch.reference <= target;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        drive_sb.note_event(mode, a, b, target);
        if (source_idle_odds != 0 && $urandom_range(1, source_idle_odds) == 1) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Extremes and the zero crossing show up more often than a flat draw gives
    function automatic logic signed [REF_W-1:0] pick_reference();
        int v;
        case ($urandom_range(0, 9))
            0: v = REF_LIMIT;
            1: v = -REF_LIMIT;
            2: v = $urandom_range(0, 2) - 1;
            default: v = $urandom_range(0, 2 * REF_LIMIT) - REF_LIMIT;
        endcase
        return v[REF_W-1:0];
    endfunction

    // Advance the encoder by one quadrature step in the given direction
    task automatic encoder_step(input bit up);
        if ((enc_a != enc_b) == up) begin
            enc_a = ~enc_a;
            issue(MODE_A_EDGE, enc_a, enc_b, pick_reference());
        end else begin
            enc_b = ~enc_b;
            issue(MODE_B_EDGE, enc_a, enc_b, pick_reference());
        end
    endtask

    // Drop valid, wait for every pending drive, then let the back end settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (drive_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both gains back to back; only called while the block is idle
    task automatic load_gains(input logic [CFG_DATA_W-1:0] prop_data,
                              input logic [CFG_DATA_W-1:0] int_data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PROP_GAIN;
        cfg_ch.data  <= prop_data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        drive_sb.set_gain(CFG_PROP_GAIN, prop_data);
        cfg_ch.index <= CFG_INTEGRAL_GAIN;
        cfg_ch.data  <= int_data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        drive_sb.set_gain(CFG_INTEGRAL_GAIN, int_data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hard stop in case the handshakes never complete
    initial begin
        #2_000_000;
        $display("FAIL quadrature_pi_position_loop_top");
        $finish;
    end

    initial begin
        bit drift_up;
        int unsigned roll;
        logic [CFG_DATA_W-1:0] prop_data;
        logic [CFG_DATA_W-1:0] int_data;

        // Hold every input at a known value while reset is asserted
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_A_EDGE;
        in_ch.level_a   <= 1'b0;
        in_ch.level_b   <= 1'b0;
        in_ch.reference <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_PROP_GAIN;
        cfg_ch.data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains: a tick at rest must give zero drive
        issue(MODE_TICK, 1'b0, 1'b0, '0);
        // Every level combination on both channels; the net move is zero
        issue(MODE_A_EDGE, 1'b0, 1'b0, '0);
        issue(MODE_A_EDGE, 1'b0, 1'b1, '0);
        issue(MODE_A_EDGE, 1'b1, 1'b0, '0);
        issue(MODE_A_EDGE, 1'b1, 1'b1, '0);
        issue(MODE_B_EDGE, 1'b0, 1'b0, '0);
        issue(MODE_B_EDGE, 1'b0, 1'b1, '0);
        issue(MODE_B_EDGE, 1'b1, 1'b0, '0);
        issue(MODE_B_EDGE, 1'b1, 1'b1, '0);
        // The unused event code must leave position and accumulator alone
        issue(MODE_UNUSED, 1'b1, 1'b0, 11'sd720);
        issue(MODE_TICK, 1'b0, 1'b1, 11'sd720);
        issue(MODE_TICK, 1'b1, 1'b0, -11'sd720);
        drain();

        // Proportional part off and the smallest integral gain: the drive
        // stays below one, so only the direction reflects the sign
        load_gains('0, 24'd1);
        issue(MODE_TICK, 1'b0, 1'b0, 11'sd720);
        issue(MODE_TICK, 1'b0, 1'b0, 11'sd720);
        issue(MODE_TICK, 1'b0, 1'b0, -11'sd720);
        issue(MODE_TICK, 1'b0, 1'b0, -11'sd720);
        issue(MODE_TICK, 1'b0, 1'b0, -11'sd720);
        drain();

        // Largest gains, with spare bits set on the proportional write:
        // saturate the drive both ways and step just off zero
        load_gains('1, '1);
        issue(MODE_TICK, 1'b0, 1'b0, 11'sd720);
        issue(MODE_TICK, 1'b0, 1'b0, -11'sd720);
        issue(MODE_TICK, 1'b0, 1'b0, -11'sd1);
        issue(MODE_TICK, 1'b0, 1'b0, 11'sd1);
        drain();

        // Both gains zero: drive is exactly zero, direction low
        load_gains('0, '0);
        issue(MODE_TICK, 1'b0, 1'b0, 11'sd5);
        drain();

        // Random phases with fresh gains; the last one runs without idling
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0: begin prop_data = '0; int_data = '0; end
                1: begin prop_data = '1; int_data = '1; end
                2: begin prop_data = PROP_GAIN_RESET; int_data = INT_GAIN_RESET; end
                3: begin
                    prop_data = CFG_DATA_W'($urandom_range(0, 4096));
                    int_data  = CFG_DATA_W'($urandom_range(0, 1 << 20));
                end
                default: begin
                    prop_data = CFG_DATA_W'($urandom);
                    int_data  = CFG_DATA_W'($urandom);
                end
            endcase
            load_gains(prop_data, int_data);

            if (phase == PHASES - 1) begin
                source_idle_odds = 0;
                sink_stall_odds  = 0;
            end else begin
                source_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
                sink_stall_odds  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            drift_up = 1'($urandom_range(0, 1));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 22) begin
                    issue(MODE_TICK, enc_a, enc_b, pick_reference());
                end else if (roll < 82) begin
                    // Mostly follow the drift so the position wanders away
                    encoder_step(($urandom_range(0, 3) != 0) ? drift_up : !drift_up);
                end else begin
                    // Noise: any code with arbitrary levels, encoder state untouched
                    issue(MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_reference());
                end
            end
            drain();
        end

        if (drive_sb.failures == 0 && drive_sb.pending() == 0)
            $display("PASS quadrature_pi_position_loop_top");
        else
            $display("FAIL quadrature_pi_position_loop_top");
        $finish;
    end

endmodule
